// ----- hdl/amre_pkg.sv -----
// ---------------------------------------------------------------------------
// Absolute-mouse report engine package
// Shared types, codes and helpers for the report engine and its sub-blocks.
// ---------------------------------------------------------------------------
package amre_pkg;

  localparam int unsigned AxisW    = 16;
  localparam int unsigned DvdW     = 31;  // 65535 * 32767 fits in 31 bits
  localparam int unsigned DivSteps = DvdW;
  localparam int unsigned DivCntW  = $clog2(DivSteps);
  localparam int unsigned CfgIdxW  = 1;
  localparam int unsigned CfgDataW = 16;

  localparam logic [CfgIdxW-1:0] CfgScreenWidth  = 1'd0;
  localparam logic [CfgIdxW-1:0] CfgScreenHeight = 1'd1;

  localparam logic [AxisW-1:0] ScreenWidthRst  = 16'd1920;
  localparam logic [AxisW-1:0] ScreenHeightRst = 16'd1080;

  localparam logic [2:0] BtnLeft   = 3'h1;
  localparam logic [2:0] BtnRight  = 3'h2;
  localparam logic [2:0] BtnMiddle = 3'h4;

  localparam logic signed [7:0] BtnIdLeft   = 8'sd1;
  localparam logic signed [7:0] BtnIdMiddle = 8'sd2;
  localparam logic signed [7:0] BtnIdRight  = 8'sd3;

  typedef enum logic [3:0] {
    ModeAbsMove  = 4'd0,
    ModeRelMove  = 4'd1,
    ModeBtnDown  = 4'd2,
    ModeBtnUp    = 4'd3,
    ModeWheel    = 4'd4,
    ModeEnter    = 4'd5,
    ModeLeave    = 4'd6,
    ModeJiggle   = 4'd7,
    ModeDisconn  = 4'd8
  } mode_e;

  typedef enum logic [2:0] {
    StIdle,
    StStart,
    StDiv,
    StDecide,
    StFlush
  } state_e;

  typedef struct packed {
    logic [3:0]        mode;
    logic [15:0]       pos_x;
    logic [15:0]       pos_y;
    logic signed [15:0] delta_x;
    logic signed [15:0] delta_y;
    logic signed [7:0]  button_id;
  } in_word_t;

  typedef struct packed {
    logic [2:0]        button_bits;
    logic [15:0]       report_x;
    logic [15:0]       report_y;
    logic signed [7:0] wheel;
    logic              last_of_run;
  } out_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic accept;     // latch the input word and update the pointer state
    logic div_start;  // load both axis dividers
    logic div_step;   // one quotient bit per axis
    logic capture;    // store a report if it differs or is forced
    logic force_emit; // the current word always emits
    logic restore;    // put the jiggled x back to its original value
    logic push;       // move the next stored report into the output register
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic changed;    // scaled report differs from the last one sent
    logic rep_any;    // at least one report is stored
    logic rep_last;   // the next report to push is the final one
    logic out_free;   // output register can take a report this cycle
  } stat_t;

  function automatic logic [2:0] button_mask(input logic signed [7:0] id);
    logic [2:0] m;
    m = 3'h0;
    if (id == BtnIdLeft) begin
      m = BtnLeft;
    end else if (id == BtnIdMiddle) begin
      m = BtnMiddle;
    end else if (id == BtnIdRight) begin
      m = BtnRight;
    end
    return m;
  endfunction

endpackage

// ----- hdl/abs_mouse_report_engine_unit.sv -----
// ---------------------------------------------------------------------------
// Absolute-mouse report engine
// Turns pointer events into absolute-mouse reports with scaled coordinates.
// ---------------------------------------------------------------------------
// Pointer events arrive as words on the input channel (in_valid_i, in_stall_o,
// in_word_i); reports leave as words on the output channel (out_valid_o,
// out_stall_i, out_word_o). A word moves at a clock edge where valid is high
// and stall is low.
// An input word is taken only while the engine is idle. Each report needs
// both axes scaled by pos*32767/(size-1), done by two restoring dividers
// that produce one quotient bit per cycle. A word that may emit a report
// runs one pass of load, division and decision; a jiggle runs two passes,
// and disconnect and unrecognised modes run no pass at all.
// The last report of a word carries last_of_run. Reports sit in a single
// output register; when the receiver stalls, the engine holds its reports and
// stops taking input until all of them have moved into the output register,
// and a report waiting in the output register does not stop the next word being taken.
// Screen size registers are written through cfg_we_i, cfg_index_i and
// cfg_data_i, by the user only while the engine is idle; the block does not
// enforce this. Reset clears the pointer state and last report, and sets 1920x1080.
// ---------------------------------------------------------------------------
module abs_mouse_report_engine_unit (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [amre_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [amre_pkg::CfgDataW-1:0] cfg_data_i,
  input  logic                          in_valid_i,
  output logic                          in_stall_o,
  input  amre_pkg::in_word_t            in_word_i,
  output logic                          out_valid_o,
  input  logic                          out_stall_i,
  output amre_pkg::out_word_t           out_word_o
);

  // Command and status between the sequencer and the datapath.
  amre_pkg::cmd_t  cmd;
  amre_pkg::stat_t stat;

  // The controller decides from the mode alone which words run a division
  // pass, which always emit and which run twice.
  amre_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .mode_i     (in_word_i.mode),
    .in_stall_o (in_stall_o),
    .cmd_o      (cmd),
    .stat_i     (stat)
  );

  // The datapath keeps the pointer state, scales the axes and holds up to
  // two reports before releasing them to the output register.
  amre_datapath u_datapath (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .in_word_i   (in_word_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_word_o  (out_word_o),
    .cmd_i       (cmd),
    .stat_o      (stat)
  );

endmodule

// ----- hdl/amre_divider.sv -----
// ---------------------------------------------------------------------------
// Axis scaling divider
// Restoring divider, one quotient bit per step; keeps the low 16 bits.
// ---------------------------------------------------------------------------
module amre_divider (
  input  logic                         clk_i,
  input  logic                         start_i,
  input  logic                         step_i,
  input  logic [amre_pkg::DvdW-1:0]    dividend_i,
  input  logic [amre_pkg::AxisW-1:0]   divisor_i,
  output logic [amre_pkg::AxisW-1:0]   quotient_o
);

  logic [amre_pkg::DvdW-1:0]  dvd_q;
  logic [amre_pkg::AxisW-1:0] rem_q;
  logic [amre_pkg::AxisW-1:0] quo_q;
  logic [amre_pkg::AxisW-1:0] dvs_q;
  logic                       zero_q;

  logic [amre_pkg::AxisW:0]   rem_sh;
  logic [amre_pkg::AxisW:0]   rem_sub;
  logic                       fits;

  always_comb begin
    rem_sh  = {rem_q, dvd_q[amre_pkg::DvdW-1]};
    fits    = rem_sh >= {1'b0, dvs_q};
    rem_sub = rem_sh - {1'b0, dvs_q};
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      dvd_q  <= dividend_i;
      rem_q  <= '0;
      quo_q  <= '0;
      dvs_q  <= divisor_i;
      zero_q <= (divisor_i == '0);
    end else if (step_i) begin
      dvd_q <= {dvd_q[amre_pkg::DvdW-2:0], 1'b0};
      rem_q <= fits ? rem_sub[amre_pkg::AxisW-1:0] : rem_sh[amre_pkg::AxisW-1:0];
      quo_q <= {quo_q[amre_pkg::AxisW-2:0], fits};
    end
  end

  // A screen of one pixel (or a span of zero) scales everything to zero.
  assign quotient_o = zero_q ? '0 : quo_q;

endmodule

// ----- hdl/amre_datapath.sv -----
// ---------------------------------------------------------------------------
// Report engine datapath
// Pointer state, screen size registers, axis dividers and report buffering.
// ---------------------------------------------------------------------------
module amre_datapath (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [amre_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [amre_pkg::CfgDataW-1:0]  cfg_data_i,
  input  amre_pkg::in_word_t             in_word_i,
  input  logic                           out_stall_i,
  output logic                           out_valid_o,
  output amre_pkg::out_word_t            out_word_o,
  input  amre_pkg::cmd_t                 cmd_i,
  output amre_pkg::stat_t                stat_o
);

  logic [15:0]       width_q, height_q;
  logic [15:0]       target_x_q, target_y_q, orig_x_q;
  logic [2:0]        buttons_q, sent_btn_q;
  logic signed [7:0] wheel_q;
  logic [15:0]       sent_x_q, sent_y_q;

  amre_pkg::out_word_t rep_q [2];
  logic [1:0]          rep_cnt_q;
  logic                rd_idx_q;
  amre_pkg::out_word_t out_q;
  logic                out_vld_q;

  logic [15:0]       span_x, span_y;
  logic [15:0]       hx, hy;
  logic [15:0]       rel_x, rel_y, jig_x;
  logic signed [7:0] wheel_sat;
  logic              emit_now;
  amre_pkg::out_word_t rep_new;

  // Relative move with the result clamped to 0 .. size-1.
  function automatic logic [15:0] clamp_step(input logic [15:0] pos,
                                             input logic signed [15:0] d,
                                             input logic [15:0] max);
    logic signed [17:0] sum;
    logic [15:0]        r;
    sum = $signed({2'b00, pos}) + $signed({{2{d[15]}}, d});
    if (sum[17]) begin
      r = '0;
    end else if (sum[16:0] > {1'b0, max}) begin
      r = max;
    end else begin
      r = sum[15:0];
    end
    return r;
  endfunction

  always_comb begin
    span_x = width_q - 16'd1;
    span_y = height_q - 16'd1;
    rel_x  = clamp_step(target_x_q, in_word_i.delta_x, span_x);
    rel_y  = clamp_step(target_y_q, in_word_i.delta_y, span_y);
    if (({1'b0, target_x_q} + 17'd1) < {1'b0, width_q}) begin
      jig_x = target_x_q + 16'd1;
    end else begin
      jig_x = target_x_q - 16'd1;
    end
    if (in_word_i.delta_y > 16'sd127) begin
      wheel_sat = 8'sd127;
    end else if (in_word_i.delta_y < -16'sd128) begin
      wheel_sat = -8'sd128;
    end else begin
      wheel_sat = in_word_i.delta_y[7:0];
    end
  end

  amre_divider u_div_x (
    .clk_i      (clk_i),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i ({target_x_q, 15'd0} - {15'd0, target_x_q}),
    .divisor_i  (span_x),
    .quotient_o (hx)
  );

  amre_divider u_div_y (
    .clk_i      (clk_i),
    .start_i    (cmd_i.div_start),
    .step_i     (cmd_i.div_step),
    .dividend_i ({target_y_q, 15'd0} - {15'd0, target_y_q}),
    .divisor_i  (span_y),
    .quotient_o (hy)
  );

  always_comb begin
    stat_o.changed  = (hx != sent_x_q) || (hy != sent_y_q) ||
                      (buttons_q != sent_btn_q) || (wheel_q != 8'sd0);
    stat_o.rep_any  = (rep_cnt_q != 2'd0);
    stat_o.rep_last = (({1'b0, rd_idx_q} + 2'd1) == rep_cnt_q);
    stat_o.out_free = !out_vld_q || !out_stall_i;
    emit_now        = cmd_i.capture && (stat_o.changed || cmd_i.force_emit);
    rep_new.button_bits = buttons_q;
    rep_new.report_x    = hx;
    rep_new.report_y    = hy;
    rep_new.wheel       = wheel_q;
    rep_new.last_of_run = 1'b0;
  end

  // Screen size registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= amre_pkg::ScreenWidthRst;
      height_q <= amre_pkg::ScreenHeightRst;
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        amre_pkg::CfgScreenWidth:  width_q  <= cfg_data_i;
        amre_pkg::CfgScreenHeight: height_q <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // Pointer state and the last report sent.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_x_q <= '0;
      target_y_q <= '0;
      orig_x_q   <= '0;
      buttons_q  <= '0;
      wheel_q    <= '0;
      sent_x_q   <= '0;
      sent_y_q   <= '0;
      sent_btn_q <= '0;
    end else begin
      if (cmd_i.accept) begin
        orig_x_q <= target_x_q;
        unique case (amre_pkg::mode_e'(in_word_i.mode))
          amre_pkg::ModeAbsMove, amre_pkg::ModeEnter: begin
            target_x_q <= in_word_i.pos_x;
            target_y_q <= in_word_i.pos_y;
          end
          amre_pkg::ModeRelMove: begin
            target_x_q <= rel_x;
            target_y_q <= rel_y;
          end
          amre_pkg::ModeBtnDown: begin
            buttons_q <= buttons_q | amre_pkg::button_mask(in_word_i.button_id);
          end
          amre_pkg::ModeBtnUp: begin
            buttons_q <= buttons_q & ~amre_pkg::button_mask(in_word_i.button_id);
          end
          amre_pkg::ModeWheel: begin
            wheel_q <= wheel_sat;
          end
          amre_pkg::ModeLeave, amre_pkg::ModeDisconn: begin
            buttons_q <= '0;
            wheel_q   <= '0;
          end
          amre_pkg::ModeJiggle: begin
            target_x_q <= jig_x;
          end
          default: ;
        endcase
      end
      if (cmd_i.restore) begin
        target_x_q <= orig_x_q;
      end
      if (emit_now) begin
        sent_x_q   <= hx;
        sent_y_q   <= hy;
        sent_btn_q <= buttons_q;
        wheel_q    <= '0;
      end
    end
  end

  // Report store: up to two reports per word, released in order.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rep_cnt_q <= '0;
      rd_idx_q  <= 1'b0;
    end else if (cmd_i.accept) begin
      rep_cnt_q <= '0;
      rd_idx_q  <= 1'b0;
    end else begin
      if (emit_now) begin
        rep_cnt_q <= rep_cnt_q + 2'd1;
      end
      if (cmd_i.push) begin
        rd_idx_q <= !rd_idx_q;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (emit_now) begin
      rep_q[rep_cnt_q[0]] <= rep_new;
    end
  end

  // Output register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_vld_q <= 1'b0;
    end else if (cmd_i.push) begin
      out_vld_q <= 1'b1;
    end else if (!out_stall_i) begin
      out_vld_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.push) begin
      out_q.button_bits <= rep_q[rd_idx_q].button_bits;
      out_q.report_x    <= rep_q[rd_idx_q].report_x;
      out_q.report_y    <= rep_q[rd_idx_q].report_y;
      out_q.wheel       <= rep_q[rd_idx_q].wheel;
      out_q.last_of_run <= stat_o.rep_last;
    end
  end

  assign out_valid_o = out_vld_q;
  assign out_word_o  = out_q;

`ifndef SYNTHESIS
  a_push_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |=> out_vld_q)
    else $error("pushed report did not reach the output register");

  a_cnt_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rep_cnt_q != 2'd3)
    else $error("report store count out of range");

  a_store_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    emit_now |-> rep_cnt_q != 2'd2)
    else $error("report captured into a full store");

  a_push_has_data: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_i.push |-> stat_o.rep_any)
    else $error("push with no stored report");
`endif

endmodule

// ----- hdl/amre_ctrl.sv -----
// ---------------------------------------------------------------------------
// Report engine controller
// Sequences state update, axis division, report decision and release.
// ---------------------------------------------------------------------------
module amre_ctrl (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            in_valid_i,
  input  logic [3:0]      mode_i,
  output logic            in_stall_o,
  output amre_pkg::cmd_t  cmd_o,
  input  amre_pkg::stat_t stat_i
);

  amre_pkg::state_e             state_q, state_d;
  logic [amre_pkg::DivCntW-1:0] cnt_q, cnt_d;
  logic                         force_q, force_d;
  logic                         jig_q, jig_d;
  logic                         pass_q, pass_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= amre_pkg::StIdle;
      cnt_q   <= '0;
      force_q <= 1'b0;
      jig_q   <= 1'b0;
      pass_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      cnt_q   <= cnt_d;
      force_q <= force_d;
      jig_q   <= jig_d;
      pass_q  <= pass_d;
    end
  end

  always_comb begin
    state_d          = state_q;
    cnt_d            = cnt_q;
    force_d          = force_q;
    jig_d            = jig_q;
    pass_d           = pass_q;
    cmd_o            = '0;
    cmd_o.force_emit = force_q;
    in_stall_o       = 1'b1;

    unique case (state_q)
      amre_pkg::StIdle: begin
        in_stall_o = 1'b0;
        if (in_valid_i) begin
          cmd_o.accept = 1'b1;
          pass_d       = 1'b0;
          force_d      = 1'b0;
          jig_d        = 1'b0;
          unique case (amre_pkg::mode_e'(mode_i))
            amre_pkg::ModeAbsMove, amre_pkg::ModeEnter,
            amre_pkg::ModeRelMove, amre_pkg::ModeLeave: begin
              state_d = amre_pkg::StStart;
            end
            amre_pkg::ModeBtnDown, amre_pkg::ModeBtnUp, amre_pkg::ModeWheel: begin
              force_d = 1'b1;
              state_d = amre_pkg::StStart;
            end
            amre_pkg::ModeJiggle: begin
              jig_d   = 1'b1;
              state_d = amre_pkg::StStart;
            end
            default: ;
          endcase
        end
      end
      amre_pkg::StStart: begin
        cmd_o.div_start = 1'b1;
        cnt_d           = '0;
        state_d         = amre_pkg::StDiv;
      end
      amre_pkg::StDiv: begin
        cmd_o.div_step = 1'b1;
        cnt_d          = cnt_q + 1'b1;
        if (cnt_q == amre_pkg::DivCntW'(amre_pkg::DivSteps - 1)) begin
          state_d = amre_pkg::StDecide;
        end
      end
      amre_pkg::StDecide: begin
        cmd_o.capture = 1'b1;
        if (jig_q && !pass_q) begin
          cmd_o.restore = 1'b1;
          pass_d        = 1'b1;
          state_d       = amre_pkg::StStart;
        end else if (stat_i.changed || force_q || stat_i.rep_any) begin
          state_d = amre_pkg::StFlush;
        end else begin
          state_d = amre_pkg::StIdle;
        end
      end
      amre_pkg::StFlush: begin
        if (stat_i.out_free) begin
          cmd_o.push = 1'b1;
          if (stat_i.rep_last) begin
            state_d = amre_pkg::StIdle;
          end
        end
      end
      default: begin
        state_d = amre_pkg::StIdle;
      end
    endcase
  end

`ifndef SYNTHESIS
  a_decide_after_div: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == amre_pkg::StDecide |-> $past(state_q) == amre_pkg::StDiv)
    else $error("decision reached without a finished division");

  a_flush_ends: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == amre_pkg::StFlush && stat_i.out_free && stat_i.rep_last)
      |=> state_q == amre_pkg::StIdle)
    else $error("flush did not end after the final report");

  a_second_pass_jiggle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.restore |-> jig_q)
    else $error("x restored outside a jiggle");
`endif

endmodule

// ----- tb/testbench.sv -----
// ---------------------------------------------------------------------------
// Absolute-mouse report engine testbench
// Drives pointer event words into the report engine, predicts every report
// from its own model of the pointer state, and checks the reports in order.
// ---------------------------------------------------------------------------
// A short scripted sequence comes first: button, wheel and move extremes,
// unknown buttons and modes, jiggle, leave and disconnect, and screen sizes of
// 0, 1 and 65535. Random words follow, with the screen size changed every few
// hundred words while the engine is idle. Both channels idle and stall at
// random, with quiet stretches in which neither side holds back.
// ---------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned RandomWords   = 1000;
  localparam int unsigned ReconfigEvery = 200;
  localparam int unsigned MaxHold       = 5;
  // A jiggle that sends nothing still keeps the engine busy for two division
  // passes, so this many cycles of silence mean the engine is idle.
  localparam int unsigned SettleCycles  = 100;
  localparam int unsigned CycleLimit    = 600000;
  localparam int unsigned NumSteps      = 26;
  localparam logic [31:0] AbsFull       = 32'd32767;

  // Modes beyond disconnect are not decoded and must be ignored.
  localparam logic [3:0] ModeUnusedLo = 4'd9;
  localparam logic [3:0] ModeUnusedHi = 4'd15;

  // One line of the scripted sequence. A screen change carries the width in
  // px and the height in py. Where typed is set, exp is the single report
  // that the word must produce; otherwise the prediction is used.
  typedef struct {
    bit                  is_cfg;
    logic [3:0]          mode;
    logic [15:0]         px;
    logic [15:0]         py;
    logic signed [15:0]  dx;
    logic signed [15:0]  dy;
    logic signed [7:0]   bid;
    bit                  typed;
    amre_pkg::out_word_t exp;
  } step_t;

  logic                          clk_i;
  logic                          rst_n       = 1'b0;
  logic                          cfg_we      = 1'b0;
  logic [amre_pkg::CfgIdxW-1:0]  cfg_index   = '0;
  logic [amre_pkg::CfgDataW-1:0] cfg_data    = '0;
  logic                          in_valid    = 1'b0;
  logic                          in_stall_o;
  amre_pkg::in_word_t            in_word     = '0;
  logic                          out_valid_o;
  logic                          out_stall_i = 1'b0;
  amre_pkg::out_word_t           out_word_o;

  // Pointer state as the engine should hold it.
  logic [15:0]       scr_w;
  logic [15:0]       scr_h;
  logic [15:0]       tgt_x;
  logic [15:0]       tgt_y;
  logic [2:0]        held;
  logic signed [7:0] wheel_due;
  logic [15:0]       sent_x;
  logic [15:0]       sent_y;
  logic [2:0]        sent_btn;

  amre_pkg::out_word_t run_q[$];        // reports caused by the word just taken
  amre_pkg::out_word_t reports_due[$];  // reports still to arrive, oldest first
  step_t               script [NumSteps];
  bit                  quiet = 1'b0;    // no idling on either side while set
  int unsigned         mismatches = 0;

  abs_mouse_report_engine_unit dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_n),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_data_i  (cfg_data),
    .in_valid_i  (in_valid),
    .in_stall_o  (in_stall_o),
    .in_word_i   (in_word),
    .out_valid_o (out_valid_o),
    .out_stall_i (out_stall_i),
    .out_word_o  (out_word_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  // ------------------------------------------------------------------------
  // Prediction
  // ------------------------------------------------------------------------

  // pos * 32767 / (size - 1), keeping the low 16 bits; a span of zero
  // (a one-pixel screen) gives zero, and size zero wraps to a span of 65535.
  function automatic logic [15:0] scale_to_report(input logic [15:0] pos,
                                                  input logic [15:0] size);
    logic [15:0] span;
    logic [31:0] quot;
    span = size - 16'd1;
    if (span == 16'd0) begin
      return 16'd0;
    end
    quot = ({16'd0, pos} * AbsFull) / {16'd0, span};
    return quot[15:0];
  endfunction

  // Relative moves may not leave the screen on either side.
  function automatic logic [15:0] clamp_to_screen(input int v, input logic [15:0] size);
    logic [15:0] top;
    top = size - 16'd1;
    if (v < 0) begin
      return 16'd0;
    end
    if (v > int'(top)) begin
      return top;
    end
    return v[15:0];
  endfunction

  function automatic logic [2:0] button_bit(input logic signed [7:0] id);
    case (id)
      amre_pkg::BtnIdLeft:   return amre_pkg::BtnLeft;
      amre_pkg::BtnIdMiddle: return amre_pkg::BtnMiddle;
      amre_pkg::BtnIdRight:  return amre_pkg::BtnRight;
      default:               return 3'h0;
    endcase
  endfunction

  function automatic void send_report();
    amre_pkg::out_word_t r;
    r.button_bits = held;
    r.report_x    = scale_to_report(tgt_x, scr_w);
    r.report_y    = scale_to_report(tgt_y, scr_h);
    r.wheel       = wheel_due;
    r.last_of_run = 1'b0;
    run_q.push_back(r);
    sent_x    = r.report_x;
    sent_y    = r.report_y;
    sent_btn  = held;
    wheel_due = 8'sd0;
  endfunction

  function automatic void send_if_changed();
    if (scale_to_report(tgt_x, scr_w) != sent_x || scale_to_report(tgt_y, scr_h) != sent_y ||
        held != sent_btn || wheel_due != 8'sd0) begin
      send_report();
    end
  endfunction

  // Applies one accepted word to the pointer state and leaves its reports,
  // the final one marked, in run_q.
  function automatic void advance_pointer(input amre_pkg::in_word_t w);
    logic [15:0] orig;
    int          step;
    run_q.delete();
    case (w.mode)
      amre_pkg::ModeAbsMove, amre_pkg::ModeEnter: begin
        tgt_x = w.pos_x;
        tgt_y = w.pos_y;
        send_if_changed();
      end
      amre_pkg::ModeRelMove: begin
        tgt_x = clamp_to_screen(int'(tgt_x) + int'($signed(w.delta_x)), scr_w);
        tgt_y = clamp_to_screen(int'(tgt_y) + int'($signed(w.delta_y)), scr_h);
        send_if_changed();
      end
      amre_pkg::ModeBtnDown: begin
        held = held | button_bit(w.button_id);
        send_report();
      end
      amre_pkg::ModeBtnUp: begin
        held = held & ~button_bit(w.button_id);
        send_report();
      end
      amre_pkg::ModeWheel: begin
        step = int'($signed(w.delta_y));
        if (step > 127) begin
          wheel_due = 8'sd127;
        end else if (step < -128) begin
          wheel_due = -8'sd128;
        end else begin
          wheel_due = step[7:0];
        end
        send_report();
      end
      amre_pkg::ModeLeave: begin
        held      = 3'h0;
        wheel_due = 8'sd0;
        send_if_changed();
      end
      amre_pkg::ModeJiggle: begin
        // Step right unless that would leave the screen, then step back.
        orig  = tgt_x;
        tgt_x = (int'(orig) + 1 < int'(scr_w)) ? orig + 16'd1 : orig - 16'd1;
        send_if_changed();
        tgt_x = orig;
        send_if_changed();
      end
      amre_pkg::ModeDisconn: begin
        held      = 3'h0;
        wheel_due = 8'sd0;
      end
      default: begin
      end
    endcase
    if (run_q.size() > 0) begin
      run_q[run_q.size() - 1].last_of_run = 1'b1;
    end
  endfunction

  function automatic logic [15:0] pick_screen_size();
    case ($urandom_range(0, 5))
      0:       return 16'd0;
      1:       return 16'hFFFF;
      2:       return 16'($urandom_range(1, 8));
      3:       return 16'($urandom_range(1, 4096));
      4:       return 16'($urandom);
      default: return amre_pkg::ScreenWidthRst;
    endcase
  endfunction

  // ------------------------------------------------------------------------
  // Channel drivers
  // ------------------------------------------------------------------------

  // Offers one word after a random gap and returns at the edge that takes it.
  task automatic present_word(input amre_pkg::in_word_t w);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, MaxHold);
    if (gap != 0) begin
      @(negedge clk_i);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk_i);
    end
    @(negedge clk_i);
    in_valid <= 1'b1;
    in_word  <= w;
    @(posedge clk_i);
    while (in_stall_o) @(posedge clk_i);
  endtask

  // Waits until the engine has gone quiet, then writes both screen registers.
  task automatic set_screen(input logic [15:0] width, input logic [15:0] height);
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    @(negedge clk_i);
    cfg_we    <= 1'b1;
    cfg_index <= amre_pkg::CfgScreenWidth;
    cfg_data  <= width;
    @(negedge clk_i);
    cfg_index <= amre_pkg::CfgScreenHeight;
    cfg_data  <= height;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    scr_w = width;
    scr_h = height;
  endtask

  // The receiver stalls for a random number of cycles before each report.
  initial begin : report_sink
    int unsigned hold;
    @(posedge rst_n);
    forever begin
      hold = quiet ? 0 : $urandom_range(0, MaxHold);
      if (hold != 0) begin
        @(negedge clk_i);
        out_stall_i <= 1'b1;
        repeat (hold - 1) @(negedge clk_i);
        @(negedge clk_i);
        out_stall_i <= 1'b0;
      end
      @(posedge clk_i);
      while (!out_valid_o) @(posedge clk_i);
    end
  end

  // ------------------------------------------------------------------------
  // Report checking
  // ------------------------------------------------------------------------

  function automatic void compare_field(input string name, input int want, input int got);
    if (want != got) begin
      $error("%s: expected %0d, got %0d", name, want, got);
      mismatches++;
    end
  endfunction

  always @(posedge clk_i) begin
    amre_pkg::out_word_t want;
    if (rst_n && out_valid_o && !out_stall_i) begin
      if (reports_due.size() == 0) begin
        $error("report with nothing expected: %h", out_word_o);
        mismatches++;
      end else begin
        want = reports_due.pop_front();
        compare_field("button_bits", int'(want.button_bits), int'(out_word_o.button_bits));
        compare_field("report_x", int'(want.report_x), int'(out_word_o.report_x));
        compare_field("report_y", int'(want.report_y), int'(out_word_o.report_y));
        compare_field("wheel", int'($signed(want.wheel)), int'($signed(out_word_o.wheel)));
        compare_field("last_of_run", int'(want.last_of_run), int'(out_word_o.last_of_run));
      end
    end
  end

  // Ends a hung run; the limit is many times the slowest correct run.
  initial begin : watchdog
    int unsigned cycles;
    cycles = 0;
    while (cycles < CycleLimit) begin
      @(posedge clk_i);
      cycles++;
    end
    $display("DONE: errors detected");
    $finish;
  end

  // ------------------------------------------------------------------------
  // Stimulus
  // ------------------------------------------------------------------------

  initial begin : stimulus
    amre_pkg::in_word_t w;
    int unsigned        taken;
    int unsigned        next_cfg;
    int unsigned        pick;
    logic [15:0]        span_x;
    logic [15:0]        span_y;

    scr_w     = amre_pkg::ScreenWidthRst;
    scr_h     = amre_pkg::ScreenHeightRst;
    tgt_x     = 16'd0;
    tgt_y     = 16'd0;
    held      = 3'h0;
    wheel_due = 8'sd0;
    sent_x    = 16'd0;
    sent_y    = 16'd0;
    sent_btn  = 3'h0;

    // Typed reports follow directly from the reset screen of 1920 by 1080,
    // where the far corner scales to full range.
    script = '{
      '{0, amre_pkg::ModeBtnDown, 16'd0, 16'd0, 16'sd0, 16'sd0, 8'sd1, 1,
        {3'd1, 16'd0, 16'd0, 8'h00, 1'b1}},
      '{0, amre_pkg::ModeAbsMove, 16'd1919, 16'd1079, 16'sd0, 16'sd0, 8'sd0, 1,
        {3'd1, 16'd32767, 16'd32767, 8'h00, 1'b1}},
      // Pushing past the corner clamps to it, so nothing is sent.
      '{0, amre_pkg::ModeRelMove, 16'd0, 16'd0, 16'sd100, 16'sd100, 8'sd0, 0, '0},
      '{0, amre_pkg::ModeRelMove, 16'd0, 16'd0, -16'sd32768, -16'sd32768, 8'sd0, 1,
        {3'd1, 16'd0, 16'd0, 8'h00, 1'b1}},
      '{0, amre_pkg::ModeBtnDown, 16'd0, 16'd0, 16'sd0, 16'sd0, 8'sd2, 1,
        {3'd5, 16'd0, 16'd0, 8'h00, 1'b1}},
      '{0, amre_pkg::ModeBtnDown, 16'd0, 16'd0, 16'sd0, 16'sd0, 8'sd3, 1,
        {3'd7, 16'd0, 16'd0, 8'h00, 1'b1}},
      // Unknown button ids change nothing but still send a report.
      '{0, amre_pkg::ModeBtnDown, 16'hFFFF, 16'hFFFF, 16'sd0, 16'sd0, -8'sd128, 1,
        {3'd7, 16'd0, 16'd0, 8'h00, 1'b1}},
      '{0, amre_pkg::ModeBtnUp, 16'd0, 16'd0, 16'sd0, 16'sd0, 8'sd127, 1,
        {3'd7, 16'd0, 16'd0, 8'h00, 1'b1}},
      '{0, amre_pkg::ModeBtnUp, 16'd0, 16'd0, 16'sd0, 16'sd0, 8'sd1, 1,
        {3'd6, 16'd0, 16'd0, 8'h00, 1'b1}},
      // Wheel steps saturate to a signed byte.
      '{0, amre_pkg::ModeWheel, 16'd0, 16'd0, 16'sd0, 16'sd32767, 8'sd0, 1,
        {3'd6, 16'd0, 16'd0, 8'h7F, 1'b1}},
      '{0, amre_pkg::ModeWheel, 16'd0, 16'd0, 16'sd0, -16'sd32768, 8'sd0, 1,
        {3'd6, 16'd0, 16'd0, 8'h80, 1'b1}},
      '{0, amre_pkg::ModeWheel, 16'd0, 16'd0, 16'sd0, -16'sd5, 8'sd0, 0, '0},
      '{0, amre_pkg::ModeEnter, 16'd960, 16'd540, 16'sd0, 16'sd0, 8'sd0, 0, '0},
      '{0, amre_pkg::ModeJiggle, 16'd0, 16'd0, 16'sd0, 16'sd0, 8'sd0, 0, '0},
      '{0, amre_pkg::ModeLeave, 16'd0, 16'd0, 16'sd0, 16'sd0, 8'sd0, 0, '0},
      '{0, amre_pkg::ModeDisconn, 16'd0, 16'd0, 16'sd0, 16'sd0, 8'sd0, 0, '0},
      '{0, ModeUnusedLo, 16'd7, 16'd7, 16'sd7, 16'sd7, 8'sd1, 0, '0},
      '{0, ModeUnusedHi, 16'hFFFF, 16'hFFFF, -16'sd1, -16'sd1, -8'sd1, 0, '0},
      // A one-pixel-wide screen scales x to zero; height zero wraps its span.
      '{1, 4'd0, 16'd1, 16'd0, 16'sd0, 16'sd0, 8'sd0, 0, '0},
      '{0, amre_pkg::ModeAbsMove, 16'hFFFF, 16'hFFFF, 16'sd0, 16'sd0, 8'sd0, 0, '0},
      '{0, amre_pkg::ModeJiggle, 16'd0, 16'd0, 16'sd0, 16'sd0, 8'sd0, 0, '0},
      // A two-pixel-high screen makes the y quotient overflow 16 bits.
      '{1, 4'd0, 16'hFFFF, 16'd2, 16'sd0, 16'sd0, 8'sd0, 0, '0},
      '{0, amre_pkg::ModeAbsMove, 16'hFFFF, 16'hFFFF, 16'sd0, 16'sd0, 8'sd0, 0, '0},
      '{0, amre_pkg::ModeRelMove, 16'd0, 16'd0, 16'sd32767, -16'sd1, 8'sd0, 0, '0},
      // At the right edge the jiggle steps left instead.
      '{0, amre_pkg::ModeJiggle, 16'd0, 16'd0, 16'sd0, 16'sd0, 8'sd0, 0, '0},
      '{1, 4'd0, amre_pkg::ScreenWidthRst, amre_pkg::ScreenHeightRst, 16'sd0, 16'sd0,
        8'sd0, 0, '0}
    };

    repeat (11) @(negedge clk_i);
    rst_n <= 1'b1;

    foreach (script[i]) begin
      if (script[i].is_cfg) begin
        set_screen(script[i].px, script[i].py);
      end else begin
        w.mode      = script[i].mode;
        w.pos_x     = script[i].px;
        w.pos_y     = script[i].py;
        w.delta_x   = script[i].dx;
        w.delta_y   = script[i].dy;
        w.button_id = script[i].bid;
        present_word(w);
        advance_pointer(w);
        if (script[i].typed) begin
          reports_due.push_back(script[i].exp);
        end else begin
          foreach (run_q[j]) reports_due.push_back(run_q[j]);
        end
      end
    end

    // Random words: positions mostly on the screen and deltas mostly small,
    // so that clamping, jiggle edges and unchanged reports all come up, with
    // full-range values mixed in.
    taken    = 0;
    next_cfg = ReconfigEvery;
    while (taken < RandomWords) begin
      if (taken >= next_cfg) begin
        set_screen(pick_screen_size(), pick_screen_size());
        next_cfg += ReconfigEvery;
      end
      quiet  = ((taken / 100) % 4) == 3;
      span_x = scr_w - 16'd1;
      span_y = scr_h - 16'd1;
      pick   = $urandom_range(0, 99);
      if (pick < 14) begin
        w.mode = amre_pkg::ModeAbsMove;
      end else if (pick < 32) begin
        w.mode = amre_pkg::ModeRelMove;
      end else if (pick < 46) begin
        w.mode = amre_pkg::ModeBtnDown;
      end else if (pick < 60) begin
        w.mode = amre_pkg::ModeBtnUp;
      end else if (pick < 68) begin
        w.mode = amre_pkg::ModeWheel;
      end else if (pick < 75) begin
        w.mode = amre_pkg::ModeEnter;
      end else if (pick < 82) begin
        w.mode = amre_pkg::ModeLeave;
      end else if (pick < 90) begin
        w.mode = amre_pkg::ModeJiggle;
      end else if (pick < 95) begin
        w.mode = amre_pkg::ModeDisconn;
      end else begin
        w.mode = 4'($urandom_range(ModeUnusedLo, ModeUnusedHi));
      end
      w.pos_x     = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, span_x))
                                               : 16'($urandom);
      w.pos_y     = ($urandom_range(0, 9) < 7) ? 16'($urandom_range(0, span_y))
                                               : 16'($urandom);
      w.delta_x   = ($urandom_range(0, 9) < 6) ? 16'($urandom_range(0, 64) - 32)
                                               : 16'($urandom);
      w.delta_y   = ($urandom_range(0, 9) < 6) ? 16'($urandom_range(0, 300) - 150)
                                               : 16'($urandom);
      w.button_id = ($urandom_range(0, 9) < 8) ? 8'($urandom_range(1, 3))
                                               : 8'($urandom);
      present_word(w);
      advance_pointer(w);
      foreach (run_q[j]) reports_due.push_back(run_q[j]);
      if (w.mode <= amre_pkg::ModeDisconn) begin
        taken++;
      end
    end

    quiet = 1'b0;
    @(negedge clk_i);
    in_valid <= 1'b0;
    while (reports_due.size() != 0) @(posedge clk_i);
    repeat (SettleCycles) @(posedge clk_i);
    if (mismatches == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule
